// ----- design/rffs_pkg.sv -----
// Shared types and constants for the fixed-length frame sync router.
// No dependencies; imported by every module of the block.
package rffs_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PayloadW    = 64;
  localparam int unsigned PayloadPos  = 7;
  localparam int unsigned RouteW      = 2;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned OutDataW    = 120;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegStartByte   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegStopByte    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegGatewayAddr = 8'd2;
  localparam logic [CfgIdxW-1:0] RegNodeAddr    = 8'd3;

  // Routing decisions
  localparam logic [RouteW-1:0] RouteGateway = 2'd0;
  localparam logic [RouteW-1:0] RouteLocal   = 2'd1;
  localparam logic [RouteW-1:0] RouteForward = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] stop_byte;
    logic [ByteW-1:0] gateway_address;
    logic [ByteW-1:0] node_address;
  } cfg_t;

  typedef struct packed {
    logic [RouteW-1:0]   route;
    logic [PayloadW-1:0] payload;
    logic [ByteW-1:0]    payload_length;
    logic [ByteW-1:0]    sensor_no;
    logic [ByteW-1:0]    iface_no;
    logic [ByteW-1:0]    request_flag;
    logic [ByteW-1:0]    command;
    logic [ByteW-1:0]    dest_id;
  } frame_t;

endpackage

// ----- design/rffs_cfg.sv -----
// Configuration register file: start/stop markers and routing addresses.
// Depends on rffs_pkg.
module rffs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rffs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rffs_pkg::ByteW-1:0]     cfg_data_i,
  output rffs_pkg::cfg_t                 cfg_o
);
  import rffs_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegStartByte:   cfg_d.start_byte      = cfg_data_i;
        RegStopByte:    cfg_d.stop_byte       = cfg_data_i;
        RegGatewayAddr: cfg_d.gateway_address = cfg_data_i;
        RegNodeAddr:    cfg_d.node_address    = cfg_data_i;
        default:        cfg_d                 = cfg_q;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte      <= 8'd91;
      cfg_q.stop_byte       <= 8'd93;
      cfg_q.gateway_address <= 8'd0;
      cfg_q.node_address    <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/rffs_window.sv -----
// Receive window: byte store, fill count, frame check, resync shift, routing.
// Depends on rffs_pkg.
module rffs_window #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rffs_pkg::cfg_t              cfg_i,
  input  logic                        step_i,      // consume byte_i this cycle
  input  logic [rffs_pkg::ByteW-1:0]  byte_i,
  output logic                        will_emit_o, // byte_i would complete a frame
  output logic                        emit_o,
  output rffs_pkg::frame_t            frame_o
);
  import rffs_pkg::*;

  localparam int unsigned IdxW     = $clog2(FRAME_BYTES);
  localparam int unsigned FlatW    = ByteW * FRAME_BYTES;
  localparam int unsigned PayBytes = (FRAME_BYTES - 8 < 8) ? FRAME_BYTES - 8 : 8;

  logic [ByteW-1:0] win_q [FRAME_BYTES];
  logic [IdxW-1:0]  fill_q, fill_d;

  logic [FlatW-1:0] flat, shifted;
  logic             last, frame_ok, found;
  logic [IdxW-1:0]  sh;

  // Complete window as it looks once byte_i lands in the last slot
  always_comb begin
    for (int j = 0; j < FRAME_BYTES - 1; j++) begin
      flat[ByteW*j +: ByteW] = win_q[j];
    end
    flat[ByteW*(FRAME_BYTES-1) +: ByteW] = byte_i;
  end

  assign last     = (fill_q == IdxW'(FRAME_BYTES - 1));
  assign frame_ok = (flat[ByteW-1:0] == cfg_i.start_byte) && (byte_i == cfg_i.stop_byte);

  assign will_emit_o = last && frame_ok;
  assign emit_o      = step_i && will_emit_o;

  // First later start byte; lowest position wins
  always_comb begin
    found = 1'b0;
    sh    = '0;
    for (int i = FRAME_BYTES - 1; i >= 1; i--) begin
      if (flat[ByteW*i +: ByteW] == cfg_i.start_byte) begin
        found = 1'b1;
        sh    = IdxW'(i);
      end
    end
  end

  assign shifted = flat >> {sh, 3'b000};

  always_comb begin
    fill_d = fill_q;
    if (step_i) begin
      if (!last) begin
        fill_d = fill_q + IdxW'(1);
      end else if (frame_ok || !found) begin
        fill_d = '0;
      end else begin
        fill_d = IdxW'(FRAME_BYTES - 1) - sh + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Window entries hold no reset: each is written before it is read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (!last) begin
        win_q[fill_q] <= byte_i;
      end else if (!frame_ok && found) begin
        for (int j = 0; j < FRAME_BYTES; j++) begin
          win_q[j] <= shifted[ByteW*j +: ByteW];
        end
      end
    end
  end

  always_comb begin
    frame_o.dest_id        = flat[ByteW*1 +: ByteW];
    frame_o.command        = flat[ByteW*2 +: ByteW];
    frame_o.request_flag   = flat[ByteW*3 +: ByteW];
    frame_o.iface_no       = flat[ByteW*4 +: ByteW];
    frame_o.sensor_no      = flat[ByteW*5 +: ByteW];
    frame_o.payload_length = flat[ByteW*6 +: ByteW];
    frame_o.payload        = PayloadW'(flat[ByteW*PayloadPos +: ByteW*PayBytes]);
    if ((frame_o.dest_id == cfg_i.gateway_address) && (frame_o.request_flag != '0)) begin
      frame_o.route = RouteGateway;
    end else if (frame_o.dest_id == cfg_i.node_address) begin
      frame_o.route = RouteLocal;
    end else begin
      frame_o.route = RouteForward;
    end
  end

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= IdxW'(FRAME_BYTES - 1))
    else $error("fill count beyond window");

endmodule

// ----- design/rx_fixed_frame_sync_router_core.sv -----
// Top level of the fixed-length frame sync router: input register, window, result register.
// Depends on rffs_pkg, rffs_cfg and rffs_window.
//
//  Channel   Dir  Handshake                      Content
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[119:0] frame fields, see port
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// One byte per cycle sustained unless a waiting result stalls a frame-completing byte. A
// byte sits in the input register while the window update, frame check and resync shift
// act on it; the frame its final byte completes is registered into the result register.
// Reset empties the window (fill count zero) and loads the default markers/addresses.
// A waiting result stalls only a byte that would complete another frame; all other
// bytes keep flowing, and the input register takes a new byte in the cycle the held one
// advances.
module rx_fixed_frame_sync_router_core #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // received bytes
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] rx_byte
  // routed frames
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] dest_id, [15:8] command, [23:16] request_flag, [31:24] iface_no,
  // [39:32] sensor_no, [47:40] payload_length, [111:48] payload, [113:112] route,
  // [119:114] zero
  output logic [rffs_pkg::OutDataW-1:0]       m_axis_tdata,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rffs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rffs_pkg::ByteW-1:0]          cfg_data_i
);
  import rffs_pkg::*;

  cfg_t             cfg;
  frame_t           frame, out_q;
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  logic             out_free, step, will_emit, emit;

  rffs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rffs_window #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .will_emit_o (will_emit),
    .emit_o      (emit),
    .frame_o     (frame)
  );

  // Result register is free when empty or being drained this cycle
  assign out_free = !out_vld_q || m_axis_tready;
  // Advance the held byte unless it completes a frame with nowhere to go
  assign step     = in_vld_q && (!will_emit || out_free);

  assign s_axis_tready = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (emit) begin
      out_q <= frame;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b000000, out_q.route, out_q.payload, out_q.payload_length,
                          out_q.sensor_no, out_q.iface_no, out_q.request_flag,
                          out_q.command, out_q.dest_id};

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("frame emitted over an undelivered result");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(emit))
    else $error("result appeared without a completed frame");

  a_held_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |=> in_vld_q && $stable(in_byte_q))
    else $error("held input byte lost or overwritten");

  a_route_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.route != 2'd3)
    else $error("illegal route code");

endmodule
